// File: src/four_digit_display_formatter_assert.svh
// assertion macros for the four-digit display formatter
// no dependencies; taken in by the top level with an include
`ifndef FOUR_DIGIT_DISPLAY_FORMATTER_ASSERT_SVH
`define FOUR_DIGIT_DISPLAY_FORMATTER_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define FDDF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fddf: %m check failed");
// antecedent implies consequent in the next cycle
`define FDDF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fddf: %m check failed");
`else
`define FDDF_ASSERT_IMP(label, clk, rst, ante, cons)
`define FDDF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/fddf_pkg.sv
// types and constants of the four-digit display formatter
// no dependencies; used by the interfaces and all modules
`default_nettype none

package fddf_pkg;

   localparam int NumDigits = 4;
   localparam int CodeW     = 6;
   localparam int DigitW    = 4;
   localparam int ValueW    = 16;
   localparam int MagW      = 14;
   localparam int PatternW  = NumDigits * CodeW;

   // range limits in 16-bit two's complement
   localparam logic [ValueW-1:0] UnderLimit = 16'hFC19;   // -999
   localparam logic [ValueW-1:0] OverLimit  = 16'd9999;

   // reciprocal multipliers: x/10, x/100, x/1000 exact for x up to 9999
   localparam logic [15:0] RecipTen      = 16'd52429;  // shift 19
   localparam logic [12:0] RecipHundred  = 13'd5243;   // shift 19
   localparam logic [13:0] RecipThousand = 14'd8389;   // shift 23

   localparam logic [DigitW-1:0] Ten = 4'd10;

   // configuration register indexes
   typedef enum logic [1:0] {
      CsrBlankCode    = 2'd0,
      CsrMinusCode    = 2'd1,
      CsrUnderPattern = 2'd2,
      CsrOverPattern  = 2'd3
   } csr_index_type;

   typedef logic [CodeW-1:0] code_type;

   typedef struct packed {
      code_type                          blank_code;
      code_type                          minus_code;
      logic [NumDigits-1:0][CodeW-1:0]   under_pattern;
      logic [NumDigits-1:0][CodeW-1:0]   over_pattern;
   } cfg_type;

   typedef struct packed {
      logic              action;
      logic [ValueW-1:0] value;
      logic [1:0]        zero_fill_pos;
      logic [2:0]        point_pos;
   } item_type;

   typedef struct packed {
      logic [NumDigits-1:0][CodeW-1:0] code;
      logic [NumDigits-1:0]            point;
   } result_type;

endpackage

`default_nettype wire

// File: src/fddf_req_if.sv
// request channel of the display formatter: one value to format
// depends on fddf_pkg for field widths
`default_nettype none

interface fddf_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [fddf_pkg::ValueW-1:0]    value;
   logic [1:0]                     zero_fill_pos;
   logic [2:0]                     point_pos;

   modport source (output valid, action, value, zero_fill_pos, point_pos, input ready);
   modport sink   (input valid, action, value, zero_fill_pos, point_pos, output ready);
endinterface

`default_nettype wire

// File: src/fddf_rsp_if.sv
// response channel of the display formatter: four codes and four points
// depends on fddf_pkg for field widths
`default_nettype none

interface fddf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fddf_pkg::CodeW-1:0]    code_digit0;
   logic [fddf_pkg::CodeW-1:0]    code_digit1;
   logic [fddf_pkg::CodeW-1:0]    code_digit2;
   logic [fddf_pkg::CodeW-1:0]    code_digit3;
   logic                          point_digit0;
   logic                          point_digit1;
   logic                          point_digit2;
   logic                          point_digit3;

   modport source (output valid, code_digit0, code_digit1, code_digit2, code_digit3,
                   point_digit0, point_digit1, point_digit2, point_digit3, input ready);
   modport sink   (input valid, code_digit0, code_digit1, code_digit2, code_digit3,
                   point_digit0, point_digit1, point_digit2, point_digit3, output ready);
endinterface

`default_nettype wire

// File: src/fddf_digits.sv
// combinational formatting of one value into four codes and points
// depends on fddf_pkg for types and constants
`default_nettype none

module fddf_digits (
   input  wire fddf_pkg::item_type   item,
   input  wire fddf_pkg::cfg_type    cfg,
   output fddf_pkg::result_type      result
);

   logic                                neg;
   logic                                under;
   logic                                over;
   logic [fddf_pkg::ValueW-1:0]         abs_val;
   logic [fddf_pkg::MagW-1:0]           mag;
   logic [29:0]                         prod_ten;
   logic [26:0]                         prod_hundred;
   logic [27:0]                         prod_thousand;
   logic [9:0]                          q_ten;
   logic [6:0]                          q_hundred;
   logic [3:0]                          q_thousand;
   logic [fddf_pkg::NumDigits-1:0][fddf_pkg::DigitW-1:0] dec_dig;
   logic [fddf_pkg::NumDigits-1:0]      dec_nz;
   logic [fddf_pkg::NumDigits-1:0]      hex_nz;
   logic [fddf_pkg::NumDigits-1:0][fddf_pkg::DigitW-1:0] dig;
   logic [fddf_pkg::NumDigits-1:0]      nz;

   // sign, range and magnitude
   assign neg     = item.value[fddf_pkg::ValueW-1];
   assign under   = neg && (item.value < fddf_pkg::UnderLimit);
   assign over    = !neg && (item.value > fddf_pkg::OverLimit);
   assign abs_val = neg ? (~item.value + 16'd1) : item.value;
   assign mag     = abs_val[fddf_pkg::MagW-1:0];

   // quotients by reciprocal multiplication
   assign prod_ten      = 30'(mag) * 30'(fddf_pkg::RecipTen);
   assign prod_hundred  = 27'(mag) * 27'(fddf_pkg::RecipHundred);
   assign prod_thousand = 28'(mag) * 28'(fddf_pkg::RecipThousand);
   assign q_ten         = prod_ten[28:19];
   assign q_hundred     = prod_hundred[25:19];
   assign q_thousand    = prod_thousand[26:23];

   // decimal digits as remainders, exact modulo 16
   assign dec_dig[0] = mag[3:0]       - q_ten[3:0]      * fddf_pkg::Ten;
   assign dec_dig[1] = q_ten[3:0]     - q_hundred[3:0]  * fddf_pkg::Ten;
   assign dec_dig[2] = q_hundred[3:0] - q_thousand      * fddf_pkg::Ten;
   assign dec_dig[3] = q_thousand;

   // digit still inside the number (not a leading zero)
   assign dec_nz = {mag >= 14'd1000, mag >= 14'd100, mag >= 14'd10, mag != 14'd0};
   assign hex_nz = {|item.value[15:12], |item.value[15:8], |item.value[15:4],
                    |item.value};

   assign dig = item.action ? item.value : dec_dig;
   assign nz  = item.action ? hex_nz : dec_nz;

   // per-digit code and point selection
   always_comb begin
      for (int d = 0; d < fddf_pkg::NumDigits; d++) begin
         if (nz[d]) begin
            result.code[d] = fddf_pkg::CodeW'(dig[d]);
         end else if (2'(d) <= item.zero_fill_pos) begin
            result.code[d] = '0;
         end else begin
            result.code[d] = cfg.blank_code;
         end
         result.point[d] = !item.action && (item.point_pos == 3'(d));
      end
      if (!item.action) begin
         if (under) begin
            result.code  = cfg.under_pattern;
            result.point = '0;
         end else if (over) begin
            result.code  = cfg.over_pattern;
            result.point = '0;
         end else if (neg) begin
            result.code[fddf_pkg::NumDigits-1] = cfg.minus_code;
         end
      end
   end

endmodule

`default_nettype wire

// File: src/four_digit_display_formatter.sv
// Four-digit display formatter. Each request carries a 16-bit value and is
// turned into four 6-bit character codes and four point bits, digit 0 rightmost,
// as signed decimal (with under/over patterns and a minus sign) or as hex.
// One request can be taken every clock cycle while results are accepted. A
// request is captured in the input register; its formatted result then
// moves into the result register, once that register is empty or its
// result transfers, and is offered on rsp from there. Both registers
// hold their item under backpressure: while a result waits the block takes
// one more request into the input register, then holds req ready low until
// the waiting result transfers. Configuration registers are written through
// csr_we/csr_index/csr_wdata and should only change while no request is in
// flight.
// Depends on fddf_pkg, fddf_req_if, fddf_rsp_if and fddf_digits.
`default_nettype none

`include "four_digit_display_formatter_assert.svh"

module four_digit_display_formatter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   fddf_req_if.sink                          req,
   fddf_rsp_if.source                        rsp,
   input  wire logic                         csr_we,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [fddf_pkg::PatternW-1:0] csr_wdata
);

   fddf_pkg::cfg_type    cfg_ff;
   fddf_pkg::cfg_type    cfg_in;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   fddf_pkg::item_type   s1_item_ff;
   fddf_pkg::item_type   s1_item_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   fddf_pkg::result_type rsp_data_ff;
   fddf_pkg::result_type rsp_data_in;
   fddf_pkg::result_type fmt_result;
   logic                 rsp_load;
   logic                 s1_load;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (fddf_pkg::csr_index_type'(csr_index))
            fddf_pkg::CsrBlankCode: begin
               cfg_in.blank_code = csr_wdata[fddf_pkg::CodeW-1:0];
            end
            fddf_pkg::CsrMinusCode: begin
               cfg_in.minus_code = csr_wdata[fddf_pkg::CodeW-1:0];
            end
            fddf_pkg::CsrUnderPattern: begin
               cfg_in.under_pattern = csr_wdata;
            end
            fddf_pkg::CsrOverPattern: begin
               cfg_in.over_pattern = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow control
   assign rsp_load  = !rsp_valid_ff || rsp.ready;
   assign s1_load   = !s1_valid_ff || rsp_load;
   assign req.ready = s1_load;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (s1_load) begin
         s1_valid_in              = req.valid;
         s1_item_in.action        = req.action;
         s1_item_in.value         = req.value;
         s1_item_in.zero_fill_pos = req.zero_fill_pos;
         s1_item_in.point_pos     = req.point_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   // formatting logic
   fddf_digits u_digits (
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (fmt_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = fmt_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // result transfer
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.code_digit0  = rsp_data_ff.code[0];
   assign rsp.code_digit1  = rsp_data_ff.code[1];
   assign rsp.code_digit2  = rsp_data_ff.code[2];
   assign rsp.code_digit3  = rsp_data_ff.code[3];
   assign rsp.point_digit0 = rsp_data_ff.point[0];
   assign rsp.point_digit1 = rsp_data_ff.point[1];
   assign rsp.point_digit2 = rsp_data_ff.point[2];
   assign rsp.point_digit3 = rsp_data_ff.point[3];

   // checks
   `FDDF_ASSERT_NXT(a_stage_moves, clock, reset, s1_valid_ff && rsp_load, rsp_valid_ff)
   `FDDF_ASSERT_IMP(a_ready_when_empty, clock, reset, !req.ready, s1_valid_ff && rsp_valid_ff)
   `FDDF_ASSERT_IMP(a_one_point, clock, reset, rsp_valid_ff, $onehot0(rsp_data_ff.point))

endmodule

`default_nettype wire
